### src/egt_pkg.sv
// Shared types, stage map and constant tables for the exposure/gamma tone mapper.
package egt_pkg;

   localparam int NUM_CH     = 3;
   localparam int FRAC_BITS  = 16;
   localparam int EXP_STEPS  = 16;

   // stage map of the per-channel pipeline
   localparam int ST_T       = 0;   // value * exposure
   localparam int ST_U       = 1;   // * log2(e)
   localparam int ST_SPLIT1  = 2;   // integer / fraction split, first exp2
   localparam int ST_EXP1    = 3;   // first of the exp2 product steps
   localparam int ST_C       = ST_EXP1 + EXP_STEPS;      // 1 - 2^-u
   localparam int ST_NORM    = ST_C + 1;                 // leading-one normalize
   localparam int ST_SQ      = ST_NORM + 1;              // first squaring step
   localparam int ST_L       = ST_SQ + FRAC_BITS;        // assemble -log2(c)
   localparam int ST_P       = ST_L + 1;                 // * inv_gamma
   localparam int ST_SPLIT2  = ST_P + 1;
   localparam int ST_EXP2    = ST_SPLIT2 + 1;
   localparam int ST_OUT     = ST_EXP2 + EXP_STEPS;      // shift, scale, special cases
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [15:0] EXPOSURE_RST  = 16'd256;
   localparam logic [15:0] INV_GAMMA_RST = 16'd1862;
   localparam logic [7:0]  BYTE_MAX  = 8'd255;

   localparam logic CSR_EXPOSURE  = 1'b0;
   localparam logic CSR_INV_GAMMA = 1'b1;

   // working word of one channel; a holds t/u/r/c/y/L/p depending on stage
   typedef struct packed {
      logic [32:0] a;
      logic [15:0] f;     // exp2 fraction, or log2 fraction being built
      logic [4:0]  n;     // exp2 shift, or leading-one position
      logic        big;   // exp2 argument too large, result is zero
      logic        zero;  // c == 0
   } chan_type;

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] b;
      rem = x;
      r   = '0;
      b   = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-(k+1)) in Q1.30
   function automatic logic [29:0] pow_rom(int k);
      logic [63:0] v;
      v = isqrt(64'h1 << 59);
      for (int i = 1; i <= k; i++)
         v = isqrt(v << 30);
      return v[29:0];
   endfunction

endpackage

### src/exposure_gamma_tonemap_top.sv
// Exposure / gamma tone mapper: three-channel HDR Q8.16 to 8-bit, fully pipelined.
// Each pixel passes through 57 register stages from the req transfer to rsp_valid.
// Throughput: one pixel per cycle unless rsp_ready stalls; 57 per-channel stages,
// each stage holding at most one multiply (exp2 products and log2 squarings).
// Stalls collapse bubbles stage by stage; nothing is dropped or repeated.
// Reset (synchronous): all stage valids clear, exposure = 1.0, inv_gamma = 1862.
module exposure_gamma_tonemap_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_hdr_red,
   input  logic [23:0] req_hdr_green,
   input  logic [23:0] req_hdr_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_ldr_red,
   output logic [7:0]  rsp_ldr_green,
   output logic [7:0]  rsp_ldr_blue,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import egt_pkg::*;

   logic [15:0] exposure_ff;
   logic [15:0] inv_gamma_ff;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_en;
   logic [23:0] hdr_in [NUM_CH];
   chan_type    stage_q [NUM_STAGES][NUM_CH];

   assign hdr_in[0] = req_hdr_red;
   assign hdr_in[1] = req_hdr_green;
   assign hdr_in[2] = req_hdr_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff  <= EXPOSURE_RST;
         inv_gamma_ff <= INV_GAMMA_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXPOSURE:  exposure_ff  <= csr_wdata;
            CSR_INV_GAMMA: inv_gamma_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage moves when it is empty or the next one moves
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--)
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0])
            valid_ff[0] <= req_valid;
         for (int s = 1; s < NUM_STAGES; s++)
            if (stage_en[s])
               valid_ff[s] <= valid_ff[s-1];
      end
   end

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
         chan_type dat_ff;
         chan_type dat_in;

         if (s == ST_T) begin : g_t
            logic [39:0] prod;
            always_comb begin
               prod     = 40'(hdr_in[ch]) * 40'(exposure_ff);
               dat_in   = '0;
               dat_in.a = {1'b0, prod[39:8]};
            end
         end else if (s == ST_U) begin : g_u
            logic [48:0] prod;
            always_comb begin
               prod     = 49'(stage_q[s-1][ch].a[31:0]) * 49'(LOG2E_Q16);
               dat_in   = stage_q[s-1][ch];
               dat_in.a = prod[48:16];
            end
         end else if (s == ST_SPLIT1 || s == ST_SPLIT2) begin : g_split
            chan_type src;
            always_comb begin
               src        = stage_q[s-1][ch];
               dat_in     = src;
               dat_in.big = (src.a[32:16] > 17'd30);
               dat_in.n   = src.a[20:16];
               dat_in.f   = src.a[15:0];
               dat_in.a   = {2'b0, ONE_Q30};
            end
         end else if ((s >= ST_EXP1 && s < ST_C) || (s >= ST_EXP2 && s < ST_OUT)) begin : g_exp
            localparam int K = (s >= ST_EXP2) ? s - ST_EXP2 : s - ST_EXP1;
            localparam logic [29:0] ROM_K = pow_rom(K);
            chan_type    src;
            logic [60:0] prod;
            always_comb begin
               src    = stage_q[s-1][ch];
               prod   = 61'(src.a[30:0]) * 61'(ROM_K);
               dat_in = src;
               if (src.f[FRAC_BITS-1-K])
                  dat_in.a = {2'b0, prod[60:30]};
            end
         end else if (s == ST_C) begin : g_c
            chan_type    src;
            logic [30:0] e;
            logic [30:0] c;
            always_comb begin
               src         = stage_q[s-1][ch];
               e           = src.big ? '0 : (src.a[30:0] >> src.n);
               c           = ONE_Q30 - e;
               dat_in      = src;
               dat_in.a    = {2'b0, c};
               dat_in.zero = (c == '0);
            end
         end else if (s == ST_NORM) begin : g_norm
            chan_type    src;
            logic [4:0]  b;
            always_comb begin
               src = stage_q[s-1][ch];
               b   = '0;
               for (int i = 0; i < 31; i++)
                  if (src.a[i])
                     b = 5'(i);
               dat_in   = src;
               dat_in.n = b;
               dat_in.f = '0;
               dat_in.a = {2'b0, src.a[30:0] << (5'd30 - b)};
            end
         end else if (s >= ST_SQ && s < ST_L) begin : g_sq
            chan_type    src;
            logic [61:0] sq;
            logic [31:0] y;
            always_comb begin
               src    = stage_q[s-1][ch];
               sq     = 62'(src.a[30:0]) * 62'(src.a[30:0]);
               y      = sq[61:30];
               dat_in = src;
               // y >= 2.0: take a result bit and renormalize
               if (y[31]) begin
                  dat_in.a = {2'b0, y[31:1]};
                  dat_in.f = {src.f[14:0], 1'b1};
               end else begin
                  dat_in.a = {2'b0, y[30:0]};
                  dat_in.f = {src.f[14:0], 1'b0};
               end
            end
         end else if (s == ST_L) begin : g_l
            chan_type    src;
            logic [20:0] l;
            always_comb begin
               src      = stage_q[s-1][ch];
               l        = {5'd30 - src.n, 16'h0} - {5'b0, src.f};
               dat_in   = src;
               dat_in.a = {12'b0, l};
            end
         end else if (s == ST_P) begin : g_p
            logic [36:0] prod;
            always_comb begin
               prod     = 37'(stage_q[s-1][ch].a[20:0]) * 37'(inv_gamma_ff);
               dat_in   = stage_q[s-1][ch];
               dat_in.a = {8'b0, prod[36:12]};
            end
         end else begin : g_out
            chan_type    src;
            logic [30:0] r;
            logic [38:0] scaled;
            always_comb begin
               src    = stage_q[s-1][ch];
               r      = src.big ? '0 : (src.a[30:0] >> src.n);
               scaled = {r, 8'b0} - {8'b0, r};
               dat_in = src;
               dat_in.a = '0;
               priority if (inv_gamma_ff == '0)
                  dat_in.a[7:0] = BYTE_MAX;
               else if (src.zero)
                  dat_in.a[7:0] = '0;
               else
                  dat_in.a[7:0] = scaled[37:30];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[s])
               dat_ff <= dat_in;
         end

         assign stage_q[s][ch] = dat_ff;
      end
   end

   assign rsp_ldr_red   = stage_q[NUM_STAGES-1][0].a[7:0];
   assign rsp_ldr_green = stage_q[NUM_STAGES-1][1].a[7:0];
   assign rsp_ldr_blue  = stage_q[NUM_STAGES-1][2].a[7:0];

`ifndef SYNTHESIS
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_C] |-> (stage_q[ST_C][0].zero == (stage_q[ST_C][0].a[30:0] == '0)))
      else $error("zero flag does not match c");

   a_log_norm: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_L-1] && !stage_q[ST_L-1][0].zero)
      |-> (stage_q[ST_L-1][0].a[30] && stage_q[ST_L-1][0].a[32:31] == 2'b0))
      else $error("log2 mantissa left [1,2)");

   a_gamma_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && inv_gamma_ff == '0)
      |-> (rsp_ldr_red == BYTE_MAX && rsp_ldr_green == BYTE_MAX && rsp_ldr_blue == BYTE_MAX))
      else $error("zero inverse gamma must give full bytes");
`endif

endmodule
